@@ rtl/i2a_pkg.sv @@
// Shared types, codes and character helpers for the integer to ASCII formatter.
// No dependencies; every other rtl file imports this package.
package i2a_pkg;

   localparam int VALUE_BITS_DEF = 64;
   localparam int VALUE_W        = 64;
   localparam int DIG_NIBBLES    = 16;
   localparam int DIG_BITS       = 4 * DIG_NIBBLES;
   localparam int MAG_BITS       = 32;
   localparam int QDEPTH         = 2;
   localparam int QPTR_BITS      = $clog2(QDEPTH);

   localparam logic [1:0] CMD_DEC  = 2'd0;
   localparam logic [1:0] CMD_HEX  = 2'd1;
   localparam logic [1:0] CMD_ADDR = 2'd2;

   localparam logic [1:0] PFX_NONE  = 2'd0;
   localparam logic [1:0] PFX_MINUS = 2'd1;
   localparam logic [1:0] PFX_0X    = 2'd2;
   localparam logic [1:0] PFX_NIL   = 2'd3;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_UA    = 8'h41;
   localparam logic [7:0] CHAR_LA    = 8'h61;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_X     = 8'h78;
   localparam logic [7:0] CHAR_LPAR  = 8'h28;
   localparam logic [7:0] CHAR_N     = 8'h6e;
   localparam logic [7:0] CHAR_I     = 8'h69;
   localparam logic [7:0] CHAR_L     = 8'h6c;
   localparam logic [7:0] CHAR_RPAR  = 8'h29;

   typedef struct packed {
      logic [1:0]         command;
      logic [VALUE_W-1:0] value;
      logic               upper_case;
   } req_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last;
      logic [4:0] total_count;
   } rsp_type;

   typedef struct packed {
      logic                is_dec;
      logic [1:0]          prefix;
      logic                upper;
      logic [DIG_BITS-1:0] data;
   } job_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
      logic [7:0] n8;
      n8 = {4'b0, nib};
      if (nib < 4'd10) begin
         return CHAR_ZERO + n8;
      end
      return (upper ? CHAR_UA : CHAR_LA) + n8 - 8'd10;
   endfunction

   function automatic logic [2:0] prefix_len(input logic [1:0] kind);
      case (kind)
         PFX_MINUS: return 3'd1;
         PFX_0X:    return 3'd2;
         PFX_NIL:   return 3'd5;
         default:   return 3'd0;
      endcase
   endfunction

   function automatic logic [7:0] prefix_char(input logic [1:0] kind, input logic [2:0] idx);
      logic [7:0] c;
      c = CHAR_ZERO;
      case (kind)
         PFX_MINUS: c = CHAR_MINUS;
         PFX_0X:    c = (idx == 3'd0) ? CHAR_ZERO : CHAR_X;
         PFX_NIL: begin
            case (idx)
               3'd0:    c = CHAR_LPAR;
               3'd1:    c = CHAR_N;
               3'd2:    c = CHAR_I;
               3'd3:    c = CHAR_L;
               default: c = CHAR_RPAR;
            endcase
         end
         default: c = CHAR_ZERO;
      endcase
      return c;
   endfunction

endpackage

@@ rtl/integer_to_ascii_formatter_core.sv @@
// Integer to ASCII formatter: number in, one ASCII character per result out.
// Depends on i2a_pkg, i2a_front and i2a_back.
//
// Input side is a queue: present req_data and raise req_push; the item is taken
// on a clock edge where req_full is low. Command 0 prints the low 32 bits as a
// signed decimal, 1 prints hex without leading zeros, 2 prints 0x and hex, or
// (nil) for zero. Reserved command 3 is dropped and yields nothing.
// Result side is a queue too: while rsp_empty is low, rsp_data holds the next
// character; raising rsp_pop takes it. last marks the final character and then
// total_count gives the length of the text.
// A two-entry job queue sits between the front end and the formatting engine.
// Per item the engine loads the job, runs 32 shift-and-add-3 steps for decimal
// only, skips one leading zero digit per cycle (up to 15), leaves the skip, then
// emits one character per cycle (1 to 18) while the receiver keeps up. A stalled
// receiver holds the engine in place; the job queue keeps accepting until it
// fills. Synchronous reset empties both queues; there are no configuration
// registers.
module integer_to_ascii_formatter_core #(
   parameter int VALUE_BITS = i2a_pkg::VALUE_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  i2a_pkg::req_type  req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output i2a_pkg::rsp_type  rsp_data
);
   import i2a_pkg::*;

   logic    job_valid;
   logic    job_take;
   job_type job;

   i2a_front #(
      .VALUE_BITS(VALUE_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .job_valid (job_valid),
      .job       (job),
      .job_take  (job_take)
   );

   i2a_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job       (job),
      .job_take  (job_take),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

@@ rtl/i2a_front.sv @@
// Front end: accepts items, classifies them into jobs, holds them in a short queue.
// Depends on i2a_pkg.
module i2a_front #(
   parameter int VALUE_BITS = i2a_pkg::VALUE_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  i2a_pkg::req_type  req_data,
   output logic              job_valid,
   output i2a_pkg::job_type  job,
   input  logic              job_take
);
   import i2a_pkg::*;

   localparam logic [VALUE_W-1:0] VALUE_MASK = {VALUE_W{1'b1}} >> (VALUE_W - VALUE_BITS);

   job_type              q_ff [QDEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]   count_ff, count_in;

   job_type              job_in;
   logic                 wr_en;
   logic                 rd_en;
   logic [31:0]          raw;
   logic [MAG_BITS-1:0]  mag;
   logic [VALUE_W-1:0]   masked;

   always_comb begin
      raw    = req_data.value[31:0];
      mag    = raw[31] ? (~raw + 32'd1) : raw;
      masked = req_data.value & VALUE_MASK;
      job_in.upper  = req_data.upper_case;
      job_in.is_dec = 1'b0;
      job_in.prefix = PFX_NONE;
      job_in.data   = DIG_BITS'(masked);
      case (req_data.command)
         CMD_DEC: begin
            job_in.is_dec = 1'b1;
            job_in.prefix = raw[31] ? PFX_MINUS : PFX_NONE;
            job_in.data   = DIG_BITS'(mag);
         end
         CMD_ADDR: begin
            job_in.prefix = (masked == '0) ? PFX_NIL : PFX_0X;
         end
         default: begin
            job_in.prefix = PFX_NONE;
         end
      endcase
   end

   assign req_full  = (count_ff == (QPTR_BITS+1)'(QDEPTH));
   assign job_valid = (count_ff != '0);
   assign job       = q_ff[rd_ptr_ff];
   assign wr_en     = req_push && !req_full && (req_data.command inside {CMD_DEC, CMD_HEX, CMD_ADDR});
   assign rd_en     = job_take && job_valid;
   assign wr_ptr_in = wr_en ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = rd_en ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign count_in  = count_ff + (QPTR_BITS+1)'(wr_en) - (QPTR_BITS+1)'(rd_en);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         q_ff[wr_ptr_ff] <= job_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/i2a_back.sv @@
// Back end: decimal conversion by shift-and-add-3, leading zero skip, character output.
// Depends on i2a_pkg; takes jobs from i2a_front.
module i2a_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  i2a_pkg::job_type  job,
   output logic              job_take,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output i2a_pkg::rsp_type  rsp_data
);
   import i2a_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CONV = 3'd1;
   localparam logic [2:0] ST_SKIP = 3'd2;
   localparam logic [2:0] ST_PRE  = 3'd3;
   localparam logic [2:0] ST_DIG  = 3'd4;

   localparam int REM_BITS  = $clog2(DIG_NIBBLES + 1);
   localparam int STEP_BITS = $clog2(MAG_BITS);

   logic [2:0]           state_ff, state_in;
   logic [DIG_BITS-1:0]  dig_ff, dig_in;
   logic [MAG_BITS-1:0]  mag_ff, mag_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic [REM_BITS-1:0]  rem_ff, rem_in;
   logic [2:0]           pidx_ff, pidx_in;
   logic [4:0]           cnt_ff, cnt_in;
   logic [1:0]           prefix_ff, prefix_in;
   logic                 upper_ff, upper_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 out_free;
   logic                 emit;
   logic [DIG_BITS-1:0]  adj;
   logic [3:0]           top_nib;
   logic                 pre_end;

   assign out_free  = !rsp_valid_ff || rsp_pop;
   assign job_take  = (state_ff == ST_IDLE) && job_valid;
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign top_nib   = dig_ff[DIG_BITS-1 -: 4];
   assign pre_end   = (pidx_ff == prefix_len(prefix_ff) - 3'd1);

   always_comb begin
      for (int i = 0; i < DIG_NIBBLES; i++) begin
         adj[4*i +: 4] = (dig_ff[4*i +: 4] >= 4'd5) ? dig_ff[4*i +: 4] + 4'd3
                                                     : dig_ff[4*i +: 4];
      end
   end

   always_comb begin
      state_in  = state_ff;
      dig_in    = dig_ff;
      mag_in    = mag_ff;
      step_in   = step_ff;
      rem_in    = rem_ff;
      pidx_in   = pidx_ff;
      cnt_in    = cnt_ff;
      prefix_in = prefix_ff;
      upper_in  = upper_ff;
      rsp_in    = rsp_ff;
      emit      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               prefix_in = job.prefix;
               upper_in  = job.upper;
               rem_in    = REM_BITS'(DIG_NIBBLES);
               pidx_in   = '0;
               cnt_in    = '0;
               step_in   = '0;
               if (job.is_dec) begin
                  dig_in   = '0;
                  mag_in   = job.data[MAG_BITS-1:0];
                  state_in = ST_CONV;
               end else begin
                  dig_in   = job.data;
                  state_in = ST_SKIP;
               end
            end
         end
         ST_CONV: begin
            dig_in  = {adj[DIG_BITS-2:0], mag_ff[MAG_BITS-1]};
            mag_in  = {mag_ff[MAG_BITS-2:0], 1'b0};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_BITS'(MAG_BITS - 1)) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (top_nib == 4'd0 && rem_ff > REM_BITS'(1)) begin
               dig_in = {dig_ff[DIG_BITS-5:0], 4'd0};
               rem_in = rem_ff - 1'b1;
            end else if (prefix_ff != PFX_NONE) begin
               state_in = ST_PRE;
            end else begin
               state_in = ST_DIG;
            end
         end
         ST_PRE: begin
            if (out_free) begin
               emit             = 1'b1;
               rsp_in.char_code = prefix_char(prefix_ff, pidx_ff);
               rsp_in.last      = pre_end && (prefix_ff == PFX_NIL);
               rsp_in.total_count = rsp_in.last ? cnt_ff + 5'd1 : 5'd0;
               cnt_in  = cnt_ff + 5'd1;
               pidx_in = pidx_ff + 3'd1;
               if (pre_end) begin
                  state_in = (prefix_ff == PFX_NIL) ? ST_IDLE : ST_DIG;
               end
            end
         end
         ST_DIG: begin
            if (out_free) begin
               emit             = 1'b1;
               rsp_in.char_code = hex_char(top_nib, upper_ff);
               rsp_in.last      = (rem_ff == REM_BITS'(1));
               rsp_in.total_count = rsp_in.last ? cnt_ff + 5'd1 : 5'd0;
               cnt_in = cnt_ff + 5'd1;
               dig_in = {dig_ff[DIG_BITS-5:0], 4'd0};
               rem_in = rem_ff - 1'b1;
               if (rem_ff == REM_BITS'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = emit ? 1'b1 : (rsp_pop ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      dig_ff    <= dig_in;
      mag_ff    <= mag_in;
      step_ff   <= step_in;
      rem_ff    <= rem_in;
      pidx_ff   <= pidx_in;
      cnt_ff    <= cnt_in;
      prefix_ff <= prefix_in;
      upper_ff  <= upper_in;
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
